/* sv/rbwfc_pkg.sv */
// shared types and codes for the rx buffer watermark flow control block
package rbwfc_pkg;

    localparam int TAG_W = 16;

    typedef enum logic [1:0] {
        OP_ARRIVE   = 2'd0,
        OP_POP_APP  = 2'd1,
        OP_POP_LINK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_PAUSE  = 2'd1,
        KIND_RESUME = 2'd2
    } kind_t;

    localparam logic DEST_APP  = 1'b0;
    localparam logic DEST_LINK = 1'b1;

    // where the result tag and kind come from
    typedef enum logic [1:0] {
        SRC_OWN  = 2'd0,
        SRC_DATA = 2'd1,
        SRC_FB   = 2'd2
    } src_t;

    typedef struct packed {
        src_t              src;
        logic              dest;
        logic [1:0]        kind;
        logic [TAG_W-1:0]  tag;
        logic              generated;
        logic              dropped;
    } res_t;

    localparam logic [8:0] BUFFER_SIZE_RST = 9'd256;

endpackage

/* sv/rbwfc_ram.sv */
// generic single write port ram with registered read
module rbwfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/rbwfc_ctrl.sv */
// queue pointers, occupancy, watermark decision and buffer_size register
module rbwfc_ctrl #(
    parameter int DATA_DEPTH = 256,
    parameter int FB_DEPTH   = 16,
    parameter int TW         = 16,
    localparam int DAW = $clog2(DATA_DEPTH),
    localparam int FAW = $clog2(FB_DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [8:0]           cfg_wr_data,
    input  logic                 accept,
    input  rbwfc_pkg::op_t       op,
    input  logic [1:0]           kind,
    input  logic [TW-1:0]        tag,
    output logic                 res_valid,
    output rbwfc_pkg::res_t      res,
    output logic                 data_we,
    output logic [DAW-1:0]       data_waddr,
    output logic [TW-1:0]        data_wdata,
    output logic                 data_re,
    output logic [DAW-1:0]       data_raddr,
    output logic                 fb_we,
    output logic [FAW-1:0]       fb_waddr,
    output logic [TW+1:0]        fb_wdata,
    output logic                 fb_re,
    output logic [FAW-1:0]       fb_raddr
);

    localparam int CW   = $clog2(DATA_DEPTH + 1);
    localparam int FCW  = $clog2(FB_DEPTH + 1);
    localparam int CAPW = (CW > 9) ? CW : 9;
    localparam int MW   = CAPW + 3;
    localparam int SW   = CW + 1;
    localparam int FSW  = FCW + 1;

    logic [8:0]     buffer_size_reg;
    logic [DAW-1:0] data_head_reg, data_head_next;
    logic [CW-1:0]  data_count_reg, data_count_next;
    logic [FAW-1:0] fb_head_reg, fb_head_next;
    logic [FCW-1:0] fb_count_reg, fb_count_next;
    logic           pause_reg, pause_next;

    logic [CAPW-1:0] cap;
    logic [CAPW-1:0] bs_ext;
    logic [CAPW-1:0] count_ext;
    logic [MW-1:0]   five_cnt, four_cnt, four_cap;
    logic            is_fb;
    logic [SW-1:0]   data_tail_sum;
    logic [SW-1:0]   data_tail;
    logic [FSW-1:0]  fb_tail_sum;
    logic [FSW-1:0]  fb_tail;
    logic [rbwfc_pkg::TAG_W-1:0] tag_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= rbwfc_pkg::BUFFER_SIZE_RST;
            data_head_reg   <= '0;
            data_count_reg  <= '0;
            fb_head_reg     <= '0;
            fb_count_reg    <= '0;
            pause_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                buffer_size_reg <= cfg_wr_data;
            end
            data_head_reg  <= data_head_next;
            data_count_reg <= data_count_next;
            fb_head_reg    <= fb_head_next;
            fb_count_reg   <= fb_count_next;
            pause_reg      <= pause_next;
        end
    end

    // capacity in use saturates at the physical depth
    assign bs_ext    = CAPW'(buffer_size_reg);
    assign cap       = (bs_ext > CAPW'(DATA_DEPTH)) ? CAPW'(DATA_DEPTH) : bs_ext;
    assign count_ext = CAPW'(data_count_reg);
    assign five_cnt  = (MW'(count_ext) << 2) + MW'(count_ext);
    assign four_cnt  = MW'(count_ext) << 2;
    assign four_cap  = MW'(cap) << 2;
    assign is_fb     = (kind == rbwfc_pkg::KIND_PAUSE) || (kind == rbwfc_pkg::KIND_RESUME);
    assign tag_ext   = rbwfc_pkg::TAG_W'(tag);

    assign data_tail_sum = SW'(data_head_reg) + SW'(data_count_reg);
    assign data_tail     = (data_tail_sum >= SW'(DATA_DEPTH))
                           ? data_tail_sum - SW'(DATA_DEPTH) : data_tail_sum;
    assign fb_tail_sum   = FSW'(fb_head_reg) + FSW'(fb_count_reg);
    assign fb_tail       = (fb_tail_sum >= FSW'(FB_DEPTH))
                           ? fb_tail_sum - FSW'(FB_DEPTH) : fb_tail_sum;

    assign data_waddr = data_tail[DAW-1:0];
    assign data_wdata = tag;
    assign data_raddr = data_head_reg;
    assign fb_waddr   = fb_tail[FAW-1:0];
    assign fb_wdata   = {kind, tag};
    assign fb_raddr   = fb_head_reg;

    always_comb
    begin
        data_head_next  = data_head_reg;
        data_count_next = data_count_reg;
        fb_head_next    = fb_head_reg;
        fb_count_next   = fb_count_reg;
        pause_next      = pause_reg;
        data_we         = 1'b0;
        data_re         = 1'b0;
        fb_we           = 1'b0;
        fb_re           = 1'b0;
        res_valid       = 1'b0;
        res.src         = rbwfc_pkg::SRC_OWN;
        res.dest        = rbwfc_pkg::DEST_APP;
        res.kind        = rbwfc_pkg::KIND_DATA;
        res.tag         = '0;
        res.generated   = 1'b0;
        res.dropped     = 1'b0;
        if (accept)
        begin
            case (op)
                rbwfc_pkg::OP_POP_APP:
                begin
                    if (data_count_reg != '0)
                    begin
                        res_valid       = 1'b1;
                        res.src         = rbwfc_pkg::SRC_DATA;
                        data_re         = 1'b1;
                        data_head_next  = (data_head_reg == DAW'(DATA_DEPTH - 1))
                                          ? '0 : data_head_reg + DAW'(1);
                        data_count_next = data_count_reg - CW'(1);
                    end
                end
                rbwfc_pkg::OP_POP_LINK:
                begin
                    if (fb_count_reg != '0)
                    begin
                        res_valid     = 1'b1;
                        res.src       = rbwfc_pkg::SRC_FB;
                        res.dest      = rbwfc_pkg::DEST_LINK;
                        fb_re         = 1'b1;
                        fb_head_next  = (fb_head_reg == FAW'(FB_DEPTH - 1))
                                        ? '0 : fb_head_reg + FAW'(1);
                        fb_count_next = fb_count_reg - FCW'(1);
                    end
                end
                rbwfc_pkg::OP_ARRIVE:
                begin
                    if (count_ext >= cap)
                    begin
                        res_valid   = 1'b1;
                        res.dest    = is_fb ? rbwfc_pkg::DEST_LINK : rbwfc_pkg::DEST_APP;
                        res.kind    = is_fb ? kind : rbwfc_pkg::KIND_DATA;
                        res.tag     = tag_ext;
                        res.dropped = 1'b1;
                    end
                    else if (is_fb)
                    begin
                        if (fb_count_reg >= FCW'(FB_DEPTH))
                        begin
                            res_valid   = 1'b1;
                            res.dest    = rbwfc_pkg::DEST_LINK;
                            res.kind    = kind;
                            res.tag     = tag_ext;
                            res.dropped = 1'b1;
                        end
                        else
                        begin
                            fb_we         = 1'b1;
                            fb_count_next = fb_count_reg + FCW'(1);
                        end
                    end
                    else
                    begin
                        // hysteresis: pause at 80 percent, resume below 25 percent
                        if ((five_cnt >= four_cap) && !pause_reg)
                        begin
                            res_valid     = 1'b1;
                            res.dest      = rbwfc_pkg::DEST_LINK;
                            res.kind      = rbwfc_pkg::KIND_PAUSE;
                            res.generated = 1'b1;
                            pause_next    = 1'b1;
                        end
                        else if ((four_cnt < MW'(cap)) && pause_reg)
                        begin
                            res_valid     = 1'b1;
                            res.dest      = rbwfc_pkg::DEST_LINK;
                            res.kind      = rbwfc_pkg::KIND_RESUME;
                            res.generated = 1'b1;
                            pause_next    = 1'b0;
                        end
                        data_we         = 1'b1;
                        data_count_next = data_count_reg + CW'(1);
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

/* sv/rbwfc_out.sv */
// result stage: merges ram read data, then holds the result for the master side
module rbwfc_out #(
    parameter int TW = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         res_valid,
    input  rbwfc_pkg::res_t              res,
    input  logic [TW-1:0]                data_rdata,
    input  logic [TW+1:0]                fb_rdata,
    output logic                         in_ready,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rbwfc_pkg::TAG_W-1:0]  m_tdata,
    output logic [4:0]                   m_tuser
);

    logic                         a_valid_reg, a_valid_next;
    rbwfc_pkg::res_t              a_res_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [rbwfc_pkg::TAG_W-1:0]  out_tag_reg;
    logic [4:0]                   out_user_reg;
    logic                         advance;
    logic [rbwfc_pkg::TAG_W-1:0]  sel_tag;
    logic [1:0]                   sel_kind;

    assign advance  = !out_valid_reg || m_tready;
    assign in_ready = !a_valid_reg || advance;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_ready)
        begin
            a_valid_next = load && res_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = a_valid_reg;
        end
    end

    // ram data is valid from the cycle after the read until the next read
    always_comb
    begin
        case (a_res_reg.src)
            rbwfc_pkg::SRC_DATA:
            begin
                sel_tag  = rbwfc_pkg::TAG_W'(data_rdata);
                sel_kind = a_res_reg.kind;
            end
            rbwfc_pkg::SRC_FB:
            begin
                sel_tag  = rbwfc_pkg::TAG_W'(fb_rdata[TW-1:0]);
                sel_kind = fb_rdata[TW+1:TW];
            end
            default:
            begin
                sel_tag  = a_res_reg.tag;
                sel_kind = a_res_reg.kind;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            a_res_reg <= res;
        end
        if (advance)
        begin
            out_tag_reg  <= sel_tag;
            out_user_reg <= {a_res_reg.dropped, a_res_reg.generated, sel_kind, a_res_reg.dest};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_tag_reg;
    assign m_tuser  = out_user_reg;

endmodule

/* sv/rx_buffer_watermark_flow_control_top.sv */
// top level: receive buffer with pause/resume watermark feedback
// one request accepted per cycle while s_tready is high; a result reaches the master side
// through the registered read of the queue rams, held beside the request, then the output register
// requests that make no result at most update the queue state
// reset: queues empty, pause flag clear, buffer_size 256; queue ram contents are not cleared
module rx_buffer_watermark_flow_control_top #(
    parameter int DATA_DEPTH = 256,
    parameter int FB_DEPTH   = 16,
    parameter int TAG_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pkt_tag
    input  logic [3:0]  s_tuser,   // op, pkt_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_tag
    output logic [4:0]  m_tuser    // dest, out_kind, generated, dropped
);

    localparam int TW  = (TAG_BITS < rbwfc_pkg::TAG_W) ? TAG_BITS : rbwfc_pkg::TAG_W;
    localparam int DAW = $clog2(DATA_DEPTH);
    localparam int FAW = $clog2(FB_DEPTH);

    logic            accept;
    logic            res_valid;
    rbwfc_pkg::res_t res;
    logic            data_we, data_re, fb_we, fb_re;
    logic [DAW-1:0]  data_waddr, data_raddr;
    logic [FAW-1:0]  fb_waddr, fb_raddr;
    logic [TW-1:0]   data_wdata, data_rdata;
    logic [TW+1:0]   fb_wdata, fb_rdata;

    assign accept = s_tvalid && s_tready;

    rbwfc_ctrl #(
        .DATA_DEPTH (DATA_DEPTH),
        .FB_DEPTH   (FB_DEPTH),
        .TW         (TW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .op          (rbwfc_pkg::op_t'(s_tuser[1:0])),
        .kind        (s_tuser[3:2]),
        .tag         (s_tdata[TW-1:0]),
        .res_valid   (res_valid),
        .res         (res),
        .data_we     (data_we),
        .data_waddr  (data_waddr),
        .data_wdata  (data_wdata),
        .data_re     (data_re),
        .data_raddr  (data_raddr),
        .fb_we       (fb_we),
        .fb_waddr    (fb_waddr),
        .fb_wdata    (fb_wdata),
        .fb_re       (fb_re),
        .fb_raddr    (fb_raddr)
    );

    rbwfc_ram #(
        .WIDTH (TW),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    rbwfc_ram #(
        .WIDTH (TW + 2),
        .DEPTH (FB_DEPTH)
    ) u_fb_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .re    (fb_re),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    rbwfc_out #(
        .TW (TW)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .res_valid  (res_valid),
        .res        (res),
        .data_rdata (data_rdata),
        .fb_rdata   (fb_rdata),
        .in_ready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

/* bench/tb_rx_buffer_watermark_flow_control_top.sv */
// testbench for the rx buffer watermark flow control top: directed table, then random traffic
`timescale 1ns / 100ps

module tb_rx_buffer_watermark_flow_control_top;

    localparam int DATA_DEPTH      = 256;
    localparam int FB_DEPTH        = 16;
    localparam int SETTLE_CYCLES   = 6;
    localparam int PRESSURE_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASE_ITEMS     = 48;
    localparam int N_PHASES        = 9;
    localparam int PRESSURE_PHASE  = 1;

    // encodings the block ignores or treats as data
    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                        dest;
        logic [1:0]                  kind;
        logic [rbwfc_pkg::TAG_W-1:0] tag;
        logic                        generated;
        logic                        dropped;
    } outcome_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [rbwfc_pkg::TAG_W-1:0] tag;
    } fb_entry_t;

    typedef struct packed {
        logic                        is_cfg;
        logic [8:0]                  size;
        logic [1:0]                  op;
        logic [1:0]                  kind;
        logic [rbwfc_pkg::TAG_W-1:0] tag;
        logic                        fixed;
        logic                        yields;
        outcome_t                    want;
    } plan_row_t;

    typedef enum logic [1:0] {
        SEG_FILL_DATA,
        SEG_FILL_FB,
        SEG_DRAIN,
        SEG_MIXED
    } seg_mode_t;

    localparam outcome_t NO_RESULT = '0;
    localparam logic     FIXED     = 1'b1;
    localparam logic     PREDICT   = 1'b0;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [8:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [3:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [4:0]  m_tuser;

    // predictor state
    logic [rbwfc_pkg::TAG_W-1:0] held_tags [$];
    fb_entry_t                   held_feedback [$];
    logic                        pause_sent = 1'b0;
    logic [8:0]                  size_limit = rbwfc_pkg::BUFFER_SIZE_RST;

    outcome_t results_due [$];
    plan_row_t plan [$];
    int  mismatch_count = 0;
    int  quiet_cycles = 0;
    bit  steady = 1'b0;
    bit  backlog_hold = 1'b0;

    rx_buffer_watermark_flow_control_top #(
        .DATA_DEPTH (DATA_DEPTH),
        .FB_DEPTH   (FB_DEPTH),
        .TAG_BITS   (rbwfc_pkg::TAG_W)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #2 clk = ~clk;

    // updates the buffer state for one request and returns 1 when a result is due
    function automatic logic predict_outcome(input logic [1:0] op, input logic [1:0] kind,
                                             input logic [rbwfc_pkg::TAG_W-1:0] tag,
                                             output outcome_t res);
        int unsigned cap;
        int unsigned count;
        logic        is_fb;
        logic        hit;
        fb_entry_t   head;
        res   = NO_RESULT;
        cap   = (size_limit > DATA_DEPTH) ? DATA_DEPTH : size_limit;
        count = held_tags.size();
        is_fb = (kind == rbwfc_pkg::KIND_PAUSE) || (kind == rbwfc_pkg::KIND_RESUME);
        hit   = 1'b0;
        case (op)
            rbwfc_pkg::OP_POP_APP:
            begin
                if (count == 0)
                    return 1'b0;
                res.dest = rbwfc_pkg::DEST_APP;
                res.kind = rbwfc_pkg::KIND_DATA;
                res.tag  = held_tags.pop_front();
                return 1'b1;
            end
            rbwfc_pkg::OP_POP_LINK:
            begin
                if (held_feedback.size() == 0)
                    return 1'b0;
                head     = held_feedback.pop_front();
                res.dest = rbwfc_pkg::DEST_LINK;
                res.kind = head.kind;
                res.tag  = head.tag;
                return 1'b1;
            end
            rbwfc_pkg::OP_ARRIVE:
            begin
                if (count >= cap)
                begin
                    res.dest    = is_fb ? rbwfc_pkg::DEST_LINK : rbwfc_pkg::DEST_APP;
                    res.kind    = is_fb ? kind : rbwfc_pkg::KIND_DATA;
                    res.tag     = tag;
                    res.dropped = 1'b1;
                    return 1'b1;
                end
                if (is_fb)
                begin
                    if (held_feedback.size() >= FB_DEPTH)
                    begin
                        res.dest    = rbwfc_pkg::DEST_LINK;
                        res.kind    = kind;
                        res.tag     = tag;
                        res.dropped = 1'b1;
                        return 1'b1;
                    end
                    held_feedback.push_back({kind, tag});
                    return 1'b0;
                end
                // occupancy is tested before the packet goes in
                if (5 * count >= 4 * cap && !pause_sent)
                begin
                    res.dest      = rbwfc_pkg::DEST_LINK;
                    res.kind      = rbwfc_pkg::KIND_PAUSE;
                    res.generated = 1'b1;
                    pause_sent    = 1'b1;
                    hit           = 1'b1;
                end
                else if (4 * count < cap && pause_sent)
                begin
                    res.dest      = rbwfc_pkg::DEST_LINK;
                    res.kind      = rbwfc_pkg::KIND_RESUME;
                    res.generated = 1'b1;
                    pause_sent    = 1'b0;
                    hit           = 1'b1;
                end
                held_tags.push_back(tag);
                return hit;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report_bad(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    task automatic offer_request(input logic [1:0] op, input logic [1:0] kind,
                                 input logic [rbwfc_pkg::TAG_W-1:0] tag, input logic fixed,
                                 input logic fixed_yields, input outcome_t fixed_res);
        outcome_t res;
        logic     yields;
        int       gap;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tuser  <= {kind, op};
        s_tdata  <= tag;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        yields = predict_outcome(op, kind, tag, res);
        if (fixed)
        begin
            yields = fixed_yields;
            res    = fixed_res;
        end
        if (yields)
            results_due.push_back(res);
    endtask

    // drain everything in flight, then write the register
    task automatic set_buffer_size(input logic [8:0] value);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        size_limit  = value;
    endtask

    initial
    begin : stimulus
        logic [8:0]  phase_sizes [N_PHASES];
        seg_mode_t   mode;
        int          seg_left;
        int          issued;
        int          roll;
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [15:0] tag;

        phase_sizes = '{9'd1, 9'd0, 9'd511, 9'd12, 9'd3, 9'd20, 9'd7, 9'd256, 9'd9};

        // after reset, size 256
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_LINK, rbwfc_pkg::KIND_DATA,
                         16'h0000, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, OP_UNUSED, KIND_UNKNOWN,
                         16'hFFFF, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'hFFFF, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_PAUSE,
                         16'h0000, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_RESUME,
                         16'hA5A5, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, KIND_UNKNOWN,
                         16'h1234, FIXED, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_APP, rbwfc_pkg::KIND_DATA, 16'hFFFF, 1'b0, 1'b0}});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_LINK, rbwfc_pkg::KIND_DATA,
                         16'h0000, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_LINK, rbwfc_pkg::KIND_PAUSE, 16'h0000, 1'b0, 1'b0}});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_LINK, rbwfc_pkg::KIND_DATA,
                         16'h0000, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_LINK, rbwfc_pkg::KIND_RESUME, 16'hA5A5, 1'b0, 1'b0}});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_APP, rbwfc_pkg::KIND_DATA, 16'h1234, 1'b0, 1'b0}});
        // zero size: every arrival is dropped
        plan.push_back('{1'b1, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0000, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h5555, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_APP, rbwfc_pkg::KIND_DATA, 16'h5555, 1'b0, 1'b1}});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_PAUSE,
                         16'h00AA, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_LINK, rbwfc_pkg::KIND_PAUSE, 16'h00AA, 1'b0, 1'b1}});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, KIND_UNKNOWN,
                         16'h0001, FIXED, 1'b1,
                         '{rbwfc_pkg::DEST_APP, rbwfc_pkg::KIND_DATA, 16'h0001, 1'b0, 1'b1}});
        // size 5: pause at four held, full at five, resume once back to one
        plan.push_back('{1'b1, 9'd5, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0000, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0010, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0011, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0012, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0013, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0014, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0015, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_POP_APP, rbwfc_pkg::KIND_DATA,
                         16'h0000, PREDICT, 1'b0, NO_RESULT});
        plan.push_back('{1'b0, 9'd0, rbwfc_pkg::OP_ARRIVE, rbwfc_pkg::KIND_DATA,
                         16'h0016, PREDICT, 1'b0, NO_RESULT});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                set_buffer_size(plan[i].size);
            else
                offer_request(plan[i].op, plan[i].kind, plan[i].tag, plan[i].fixed,
                              plan[i].yields, plan[i].want);
        end

        // random traffic in fill, drain and mixed stretches so both queues hit their limits
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_buffer_size(phase_sizes[p]);
            if (p == PRESSURE_PHASE)
                backlog_hold = 1'b1;
            if (p == N_PHASES - 1)
                steady = 1'b1;
            issued   = 0;
            seg_left = 0;
            while (issued < PHASE_ITEMS)
            begin
                if (seg_left == 0)
                begin
                    mode     = seg_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(4, 24);
                end
                seg_left--;
                roll = $urandom_range(0, 99);
                case (mode)
                    SEG_FILL_DATA, SEG_FILL_FB:
                        op = (roll < 85) ? rbwfc_pkg::OP_ARRIVE :
                             (roll < 92) ? rbwfc_pkg::OP_POP_APP :
                             (roll < 98) ? rbwfc_pkg::OP_POP_LINK : OP_UNUSED;
                    SEG_DRAIN:
                        op = (roll < 25) ? rbwfc_pkg::OP_ARRIVE :
                             (roll < 65) ? rbwfc_pkg::OP_POP_APP :
                             (roll < 97) ? rbwfc_pkg::OP_POP_LINK : OP_UNUSED;
                    default:
                        op = (roll < 45) ? rbwfc_pkg::OP_ARRIVE :
                             (roll < 70) ? rbwfc_pkg::OP_POP_APP :
                             (roll < 96) ? rbwfc_pkg::OP_POP_LINK : OP_UNUSED;
                endcase
                roll = $urandom_range(0, 99);
                if (mode == SEG_FILL_FB)
                    kind = (roll < 40) ? rbwfc_pkg::KIND_PAUSE :
                           (roll < 80) ? rbwfc_pkg::KIND_RESUME :
                           (roll < 92) ? rbwfc_pkg::KIND_DATA : KIND_UNKNOWN;
                else
                    kind = (roll < 70) ? rbwfc_pkg::KIND_DATA :
                           (roll < 80) ? KIND_UNKNOWN :
                           (roll < 90) ? rbwfc_pkg::KIND_PAUSE : rbwfc_pkg::KIND_RESUME;
                case ($urandom_range(0, 9))
                    0:       tag = 16'h0000;
                    1:       tag = 16'hFFFF;
                    default: tag = 16'($urandom);
                endcase
                offer_request(op, kind, tag, PREDICT, 1'b0, NO_RESULT);
                if (op != OP_UNUSED)
                    issued++;
            end
        end

        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("rx_buffer_watermark_flow_control_top verification clean");
        else
            $display("rx_buffer_watermark_flow_control_top verification failed");
        $finish;
    end

    // result side: random stall bursts, one long hold-off to back up the block
    initial
    begin : receiver
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (backlog_hold)
            begin
                backlog_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t got;
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tuser[2:1], m_tdata, m_tuser[3], m_tuser[4]};
            if (results_due.size() == 0)
                report_bad($sformatf("unexpected result dest %0d kind %0d tag %h gen %0d drop %0d",
                                     got.dest, got.kind, got.tag, got.generated, got.dropped));
            else
            begin
                want = results_due.pop_front();
                if (got.dest !== want.dest || got.kind !== want.kind || got.tag !== want.tag ||
                    got.generated !== want.generated || got.dropped !== want.dropped)
                    report_bad($sformatf({"mismatch: expected dest %0d kind %0d tag %h gen %0d ",
                                          "drop %0d, got dest %0d kind %0d tag %h gen %0d drop %0d"},
                                         want.dest, want.kind, want.tag, want.generated,
                                         want.dropped, got.dest, got.kind, got.tag,
                                         got.generated, got.dropped));
            end
        end
    end

    // ends the run when no request moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("rx_buffer_watermark_flow_control_top verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

/* rx_buffer_watermark_flow_control_top.f */
sv/rbwfc_pkg.sv
sv/rbwfc_ram.sv
sv/rbwfc_ctrl.sv
sv/rbwfc_out.sv
sv/rx_buffer_watermark_flow_control_top.sv
bench/tb_rx_buffer_watermark_flow_control_top.sv
